### rtl/dfp_pkg.sv
// Package with the shared types, constants and header functions of the diagnostic frame packer.
package dfp_pkg;

    localparam logic [7:0] HDR_FMT_80 = 8'h80;
    localparam logic [7:0] HDR_FMT_C0 = 8'hC0;
    localparam logic [7:0] HDR_FMT_00 = 8'h00;

    typedef enum logic [2:0] {
        FMT_LEN_IN_80 = 3'd0,
        FMT_LEN_IN_C0 = 3'd1,
        FMT_80_LEN    = 3'd2,
        FMT_00_LEN    = 3'd3,
        FMT_LEN_ONLY  = 3'd4
    } t_frame_fmt;

    typedef enum logic [1:0] {
        CFG_FRAME_FORMAT = 2'd0,
        CFG_TARGET_ADDR  = 2'd1,
        CFG_SOURCE_ADDR  = 2'd2
    } t_cfg_idx;

    // One classified payload byte, handed from the front end to the byte emitter.
    typedef struct packed {
        logic       first;
        logic       last;
        logic [2:0] fmt;
        logic [7:0] len;
        logic [7:0] tgt;
        logic [7:0] src;
        logic [7:0] data;
    } t_cmd;

    localparam int CMD_Q_DEPTH = 4;
    localparam int CMD_Q_AW    = $clog2(CMD_Q_DEPTH);

    function automatic logic [2:0] hdr_count(input logic [2:0] fmt);
        logic [2:0] cnt;
        unique case (fmt) inside
            FMT_LEN_IN_80, FMT_LEN_IN_C0: cnt = 3'd3;
            FMT_80_LEN:                   cnt = 3'd4;
            FMT_00_LEN:                   cnt = 3'd2;
            default:                      cnt = 3'd1;
        endcase
        return cnt;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [2:0] fmt, input logic [1:0] idx,
                                           input logic [7:0] len, input logic [7:0] tgt,
                                           input logic [7:0] src);
        logic [7:0] b;
        b = len;
        unique case (fmt) inside
            FMT_LEN_IN_80, FMT_LEN_IN_C0: begin
                case (idx)
                    2'd0:    b = ((fmt == FMT_LEN_IN_80) ? HDR_FMT_80 : HDR_FMT_C0) | len;
                    2'd1:    b = tgt;
                    default: b = src;
                endcase
            end
            FMT_80_LEN: begin
                case (idx)
                    2'd0:    b = HDR_FMT_80;
                    2'd1:    b = tgt;
                    2'd2:    b = src;
                    default: b = len;
                endcase
            end
            FMT_00_LEN: begin
                b = (idx == 2'd0) ? HDR_FMT_00 : len;
            end
            default: begin
                b = len;
            end
        endcase
        return b;
    endfunction

endpackage

### rtl/dfp_in_if.sv
// Input channel interface carrying payload bytes and the frame length.
interface dfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;

    modport source (output valid, output payload_byte, output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface

### rtl/dfp_out_if.sv
// Output channel interface carrying framed bytes and the end-of-frame mark.
interface dfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

### rtl/dfp_front.sv
// Front end: configuration registers, frame tracking and classification of input bytes.
module dfp_front
    import dfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    dfp_in_if.sink     i_in_ch,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    logic [2:0] r_fmt;
    logic [7:0] r_tgt;
    logic [7:0] r_src;
    logic [7:0] r_bytes_left;
    logic [7:0] n_bytes_left;
    logic [7:0] remaining;
    logic       start;
    logic       accept;

    assign i_in_ch.ready = i_cmd_ready;
    assign accept        = i_in_ch.valid && i_cmd_ready;
    assign start         = (r_bytes_left == 8'd0);
    assign remaining     = start ? i_in_ch.payload_length : r_bytes_left;

    // A zero length at frame start is dropped without a trace.
    assign o_cmd_valid = accept && (remaining != 8'd0);

    always_comb begin
        o_cmd.first = start;
        o_cmd.last  = (remaining == 8'd1);
        o_cmd.fmt   = r_fmt;
        o_cmd.len   = i_in_ch.payload_length;
        o_cmd.tgt   = r_tgt;
        o_cmd.src   = r_src;
        o_cmd.data  = i_in_ch.payload_byte;
        n_bytes_left = r_bytes_left;
        if (o_cmd_valid) begin
            n_bytes_left = remaining - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= 3'd0;
            r_tgt        <= 8'd0;
            r_src        <= 8'd0;
            r_bytes_left <= 8'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_FORMAT: r_fmt <= i_cfg_data[2:0];
                    CFG_TARGET_ADDR:  r_tgt <= i_cfg_data;
                    CFG_SOURCE_ADDR:  r_src <= i_cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

### rtl/dfp_cmd_queue.sv
// Small command queue between the front end and the byte emitter.
module dfp_cmd_queue
    import dfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                r_mem [CMD_Q_DEPTH];
    logic [CMD_Q_AW-1:0] r_wr_ptr;
    logic [CMD_Q_AW-1:0] r_rd_ptr;
    logic [CMD_Q_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_count != (CMD_Q_AW+1)'(CMD_Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (CMD_Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (CMD_Q_AW+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

### rtl/dfp_back.sv
// Byte emitter: turns commands into header, data and checksum bytes.
module dfp_back
    import dfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_cmd_pop,
    dfp_out_if.source o_out_ch
);

    t_cmd       r_cmd;
    logic       r_cmd_valid;
    logic [2:0] r_step;
    logic [7:0] r_sum;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    logic [2:0] hdr_len;
    logic [2:0] last_step;
    logic       out_free;
    logic       emit;
    logic       done;
    logic       is_ck;
    logic [7:0] cur_byte;
    logic [7:0] sum_base;

    assign hdr_len   = r_cmd.first ? hdr_count(r_cmd.fmt) : 3'd0;
    assign last_step = hdr_len + {2'b00, r_cmd.last};
    assign out_free  = !r_out_valid || o_out_ch.ready;
    assign emit      = r_cmd_valid && out_free;
    assign done      = emit && (r_step == last_step);
    assign o_cmd_pop = (!r_cmd_valid || done) && i_cmd_valid;
    assign is_ck     = (r_step > hdr_len);
    // The sum restarts with the first byte of every frame.
    assign sum_base  = (r_cmd.first && r_step == 3'd0) ? 8'd0 : r_sum;

    always_comb begin
        if (r_step < hdr_len) begin
            cur_byte = hdr_byte(r_cmd.fmt, r_step[1:0], r_cmd.len, r_cmd.tgt, r_cmd.src);
        end else if (r_step == hdr_len) begin
            cur_byte = r_cmd.data;
        end else begin
            cur_byte = r_sum;
        end
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.frame_byte = r_out_byte;
    assign o_out_ch.frame_end  = r_out_end;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_end  <= is_ck;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_step      <= 3'd0;
            r_sum       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_cmd_valid <= 1'b1;
            end else if (done) begin
                r_cmd_valid <= 1'b0;
            end
            if (o_cmd_pop || done) begin
                r_step <= 3'd0;
            end else if (emit) begin
                r_step <= r_step + 3'd1;
            end
            if (emit && !is_ck) begin
                r_sum <= sum_base + cur_byte;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/diag_frame_packer_unit.sv
// Top level of the diagnostic frame packer.
//
// Payload bytes arrive on i_in_ch together with the frame length, which is
// sampled on the first byte of each frame; a zero length at frame start is
// discarded. Framed bytes leave on o_out_ch: the header for the configured
// format, the payload bytes, and an 8-bit additive checksum marked with
// frame_end. The user writes registers (format, target, source) through the
// i_cfg_* port only while the block is idle; the block does not enforce it.
// They apply from the next frame.
// The front end classifies one input transaction per cycle into a four-entry
// command queue while the queue has room; the emitter drains it at one
// output byte per cycle while the receiver is ready. A middle payload byte
// therefore yields one output byte, the first byte of a frame up to five
// (header plus data), the last byte one more for the checksum. When the
// receiver stalls, the output register holds its byte, the queue fills, and
// input ready drops. Synchronous reset empties the queue, clears the frame
// state and the registers.
module diag_frame_packer_unit
    import dfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    dfp_in_if.sink     i_in_ch,
    dfp_out_if.source  o_out_ch
);

    logic f_cmd_valid;
    t_cmd f_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic b_pop;

    dfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_ch     (i_in_ch),
        .o_cmd_valid (f_cmd_valid),
        .o_cmd       (f_cmd),
        .i_cmd_ready (q_ready)
    );

    dfp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_valid),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (b_pop)
    );

    dfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (b_pop),
        .o_out_ch    (o_out_ch)
    );

endmodule
